// ===== rtl/cset_pkg.sv =====
// shared types and constants of the call stack exclusive time profiler
package cset_pkg;

  localparam int ID_W    = 6;
  localparam int TOTAL_W = 32;
  localparam int LEVEL_W = 7;
  localparam int RC_W    = 7;
  localparam int DELTA_W = 33;

  localparam logic [RC_W-1:0]    RC_RESET  = 7'd64;
  localparam logic [DELTA_W-1:0] DELTA_CAP = 33'h1_0000_0000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_OVERFLOW,
    ERR_EMPTY,
    ERR_BAD_ID,
    ERR_BACKWARDS
  } err_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    logic               credit;
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
    logic [LEVEL_W-1:0] level;
    err_t               err;
  } mid_t;

  typedef struct packed {
    logic               credit;
    logic [ID_W-1:0]    id;
    logic [TOTAL_W-1:0] total;
    logic [LEVEL_W-1:0] level;
    err_t               err;
  } res_t;

endpackage

// ===== rtl/cset_fifo.sv =====
// small register queue used between the profiler stages
module cset_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/cset_front.sv =====
// front end: event checks, call stack, time mark and credit classification
module cset_front #(
  parameter int MAX_ROUTINES = 64,
  parameter int STACK_DEPTH  = 64,
  parameter int TIME_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          func,
  input  logic [cset_pkg::ID_W-1:0]     routine_id,
  input  logic [TIME_BITS-1:0]          timestamp,
  input  logic [cset_pkg::RC_W-1:0]     routine_count,
  output cset_pkg::mid_t                entry
);

  localparam int PW  = TIME_BITS + 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int DW  = (PW > cset_pkg::DELTA_W) ? PW : cset_pkg::DELTA_W;

  logic [cset_pkg::ID_W-1:0] stack_mem [STACK_DEPTH];
  logic [SPW-1:0]            sp_r, sp_nxt;
  logic [PW-1:0]             prev_r, prev_nxt;
  logic [cset_pkg::ID_W-1:0] top_r;

  logic [PW-1:0]                ts_ext, ts_end, mark;
  logic [DW-1:0]                delta_full;
  logic [cset_pkg::DELTA_W-1:0] delta;
  logic                         id_ok, stack_full, stack_empty, ok, credit;
  cset_pkg::err_t               err;

  always_comb begin
    ts_ext      = PW'(timestamp);
    ts_end      = ts_ext + PW'(1);
    mark        = func ? ts_end : ts_ext;
    id_ok       = (cset_pkg::RC_W'(routine_id) < routine_count) &&
                  (int'(routine_id) < MAX_ROUTINES);
    stack_full  = (sp_r == SPW'(STACK_DEPTH));
    stack_empty = (sp_r == '0);

    if (!id_ok) begin
      err = cset_pkg::ERR_BAD_ID;
    end else if (!func && stack_full) begin
      err = cset_pkg::ERR_OVERFLOW;
    end else if (func && stack_empty) begin
      err = cset_pkg::ERR_EMPTY;
    end else if (mark < prev_r) begin
      err = cset_pkg::ERR_BACKWARDS;
    end else begin
      err = cset_pkg::ERR_OK;
    end

    ok     = (err == cset_pkg::ERR_OK);
    credit = ok && !stack_empty;

    // anything past 2^32 saturates the total anyway
    delta_full = DW'(mark - prev_r);
    delta      = (delta_full > DW'(cset_pkg::DELTA_CAP)) ? cset_pkg::DELTA_CAP :
                 cset_pkg::DELTA_W'(delta_full);

    sp_nxt   = sp_r;
    prev_nxt = prev_r;
    if (ok) begin
      prev_nxt = mark;
      sp_nxt   = func ? sp_r - SPW'(1) : sp_r + SPW'(1);
    end

    entry.credit = credit;
    entry.id     = credit ? top_r : '0;
    entry.delta  = credit ? delta : '0;
    entry.level  = cset_pkg::LEVEL_W'(sp_nxt);
    entry.err    = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      prev_r <= '0;
    end else if (accept) begin
      sp_r   <= sp_nxt;
      prev_r <= prev_nxt;
    end
  end

  // top of stack mirrored in a register, refilled from the memory on pop
  always_ff @(posedge clk) begin
    if (accept && ok) begin
      if (!func) begin
        stack_mem[SW'(sp_r)] <= routine_id;
        top_r                <= routine_id;
      end else begin
        top_r <= stack_mem[SW'(sp_r - SPW'(2))];
      end
    end
  end

endmodule

// ===== rtl/cset_back.sv =====
// back end: accumulator table clear, saturating update and result queue
module cset_back #(
  parameter int MAX_ROUTINES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cset_pkg::mid_t mid_data,
  input  logic           mid_empty,
  output logic           mid_pop,
  output logic           busy,
  output cset_pkg::res_t res,
  output logic           res_empty,
  input  logic           res_pop
);

  localparam int AW = $clog2(MAX_ROUTINES);

  logic [cset_pkg::TOTAL_W-1:0] acc_mem [MAX_ROUTINES];

  cset_pkg::back_state_t state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic                  clearing;

  logic                         s1_vld_r;
  cset_pkg::mid_t               s1_r;
  logic [cset_pkg::TOTAL_W-1:0] rd_r, fwd_total_r, base, total;
  logic                         fwd_r;
  logic [cset_pkg::TOTAL_W+1:0] sum;
  logic [AW-1:0]                new_idx, s1_idx;
  logic                         retire, take, res_full;
  cset_pkg::res_t               res_in;
  logic [$bits(cset_pkg::res_t)-1:0] res_q;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cset_pkg::ST_CLEAR: begin
        if (clr_r == AW'(MAX_ROUTINES - 1)) begin
          state_nxt = cset_pkg::ST_RUN;
        end
      end
      cset_pkg::ST_RUN: state_nxt = cset_pkg::ST_RUN;
      default:          state_nxt = cset_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state_r)
      cset_pkg::ST_CLEAR: clearing = 1'b1;
      cset_pkg::ST_RUN:   clearing = 1'b0;
      default:            clearing = 1'b1;
    endcase
    clr_nxt = clearing ? clr_r + AW'(1) : clr_r;
  end

  assign busy    = clearing;
  assign new_idx = AW'(mid_data.id);
  assign s1_idx  = AW'(s1_r.id);
  assign retire  = s1_vld_r && !res_full;
  assign take    = !clearing && !mid_empty && (!s1_vld_r || retire);
  assign mid_pop = take;

  always_comb begin
    base  = fwd_r ? fwd_total_r : rd_r;
    sum   = (cset_pkg::TOTAL_W+2)'(base) + (cset_pkg::TOTAL_W+2)'(s1_r.delta);
    total = (sum > (cset_pkg::TOTAL_W+2)'(cset_pkg::TOTAL_MAX)) ? cset_pkg::TOTAL_MAX :
            sum[cset_pkg::TOTAL_W-1:0];

    res_in.credit = s1_r.credit;
    res_in.id     = s1_r.id;
    res_in.total  = s1_r.credit ? total : '0;
    res_in.level  = s1_r.level;
    res_in.err    = s1_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cset_pkg::ST_CLEAR;
      clr_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (take) begin
        s1_vld_r <= 1'b1;
      end else if (retire) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  // read for the incoming entry, forward if the retiring one writes the same id
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r        <= mid_data;
      rd_r        <= acc_mem[new_idx];
      fwd_r       <= retire && s1_r.credit && (s1_idx == new_idx);
      fwd_total_r <= total;
    end
    if (clearing) begin
      acc_mem[clr_r] <= '0;
    end else if (retire && s1_r.credit) begin
      acc_mem[s1_idx] <= total;
    end
  end

  cset_fifo #(
    .WIDTH ($bits(cset_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (retire),
    .push_data (res_in),
    .full      (res_full),
    .pop       (res_pop),
    .pop_data  (res_q),
    .empty     (res_empty)
  );

  assign res = cset_pkg::res_t'(res_q);

endmodule

// ===== rtl/call_stack_exclusive_time.sv =====
// top level of the call stack exclusive time profiler
// trace events enter through a queue style port: in_func, in_routine_id and
// in_timestamp transfer at a clock edge with push high and full low.
// results leave the same way: the oldest result sits on the out_ ports while
// empty is low and transfers at an edge with pop high.
// every event gives exactly one result, in order.
// one event can transfer every cycle while full is low; each event passes through the
// event queue, the accumulator read stage and the result queue, in that order, on
// its way to the out_ ports.
// the accumulator read-modify-write forwards back to back updates.
// routine_count is written over cfg_valid/cfg_ready/cfg_data, ready always high;
// the user must write it only while the block is idle; the block does not enforce this.
// after reset the accumulator table is swept to zero, one entry a cycle, over all
// MAX_ROUTINES entries; full stays high during the sweep. the stack and time
// mark start at zero and routine_count at 64.
// when pop is held low, two results wait in the result queue, one in the read
// stage and two events in the event queue; full then rises and input stalls.
module call_stack_exclusive_time #(
  parameter int MAX_ROUTINES = 64,
  parameter int STACK_DEPTH  = 64,
  parameter int TIME_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_func,
  input  logic [cset_pkg::ID_W-1:0]        in_routine_id,
  input  logic [TIME_BITS-1:0]             in_timestamp,
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_credit_valid,
  output logic [cset_pkg::ID_W-1:0]        out_credited_id,
  output logic [cset_pkg::TOTAL_W-1:0]     out_credited_total,
  output logic [cset_pkg::LEVEL_W-1:0]     out_stack_level,
  output logic [2:0]                       out_error_code,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cset_pkg::RC_W-1:0]        cfg_data
);

  logic [cset_pkg::RC_W-1:0]         rc_r;
  logic                              accept, busy;
  logic                              mid_full, mid_empty, mid_pop;
  cset_pkg::mid_t                    entry, mid_data;
  logic [$bits(cset_pkg::mid_t)-1:0] mid_q;
  cset_pkg::res_t                    res;

  assign cfg_ready = 1'b1;
  assign full      = mid_full || busy;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= cset_pkg::RC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rc_r <= cfg_data;
    end
  end

  cset_front #(
    .MAX_ROUTINES (MAX_ROUTINES),
    .STACK_DEPTH  (STACK_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .func          (in_func),
    .routine_id    (in_routine_id),
    .timestamp     (in_timestamp),
    .routine_count (rc_r),
    .entry         (entry)
  );

  cset_fifo #(
    .WIDTH ($bits(cset_pkg::mid_t)),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (entry),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_q),
    .empty     (mid_empty)
  );

  assign mid_data = cset_pkg::mid_t'(mid_q);

  cset_back #(
    .MAX_ROUTINES (MAX_ROUTINES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_data  (mid_data),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .busy      (busy),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign out_credit_valid   = res.credit;
  assign out_credited_id    = res.id;
  assign out_credited_total = res.total;
  assign out_stack_level    = res.level;
  assign out_error_code     = res.err;

  a_credit_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_credit_valid) |-> (out_error_code == cset_pkg::ERR_OK))
    else $error("credited result carries an error code");

  a_no_credit_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_credit_valid) |-> (out_credited_total == '0 && out_credited_id == '0))
    else $error("uncredited result has non-zero id or total");

  a_no_take_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !mid_pop)
    else $error("event taken while the accumulator table is being cleared");

  a_mid_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !mid_full)
    else $error("event queue written while full");

endmodule
